### hw/rtl/assert_macros.svh
// Assertion macros for the checker file of the matrix inverse block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is high.
`define MI4_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, checked during reset as well.
`define MI4_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/mi4_pkg.sv
// Shared constants, tables and helpers of the 4x4 matrix inverse block.
// No dependencies.
package mi4_pkg;

   localparam int PORT_W    = 32;
   localparam int IDX_W     = 4;
   localparam int USER_W    = IDX_W + 1;
   localparam int TERMS     = 6;
   localparam int TERM_W    = 3;
   localparam int LAST_IDX  = 15;
   localparam int DET_LAST  = 3;

   // Sarrus column selection per term; first three terms add, last three subtract
   localparam logic [1:0] PERM_TAB [TERMS][3] = '{
      '{2'd0, 2'd1, 2'd2}, '{2'd1, 2'd2, 2'd0}, '{2'd2, 2'd0, 2'd1},
      '{2'd2, 2'd1, 2'd0}, '{2'd1, 2'd0, 2'd2}, '{2'd0, 2'd2, 2'd1}
   };
   localparam logic [TERM_W-1:0] FIRST_SUB_TERM = 3'd3;

   // n-th index of the minor that leaves out row or column skip
   function automatic logic [1:0] minor_idx(input logic [1:0] n, input logic [1:0] skip);
      return (n < skip) ? n : n + 2'd1;
   endfunction

   // element address {col,row} of factor n of term t of cofactor (i,j)
   function automatic logic [IDX_W-1:0] term_addr(input logic [TERM_W-1:0] t,
                                                  input logic [1:0] n,
                                                  input logic [1:0] i,
                                                  input logic [1:0] j);
      return {minor_idx(PERM_TAB[t][n], j), minor_idx(n, i)};
   endfunction

endpackage

### hw/rtl/mi4_mul.sv
// Limb-serial signed multiplier: wide operand times DATA_WIDTH-bit operand.
// One DATA_WIDTH x DATA_WIDTH product per cycle. No package dependencies.
module mi4_mul #(
   parameter int W  = 32,
   parameter int XW = 131
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [XW-1:0] x,
   input  logic signed [W-1:0]  e,
   output logic                 done,
   output logic signed [XW-1:0] prod
);

   localparam int NL    = (XW + W - 1) / W;
   localparam int AW    = NL * W;
   localparam int CNT_W = $clog2(NL + 1);

   logic                 busy_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [AW-1:0]        xm_ff;
   logic [W-1:0]         em_ff;
   logic                 neg_ff;
   logic [2*W-1:0]       pp_ff;
   logic [AW-1:0]        acc_ff;
   logic                 done_ff;
   logic signed [XW-1:0] prod_ff;

   logic [XW-1:0] x_abs;
   logic [W-1:0]  e_abs;
   logic [AW-1:0] acc_in;
   logic [XW-1:0] mag;

   assign x_abs  = x[XW-1] ? XW'(-x) : XW'(x);
   assign e_abs  = e[W-1] ? W'(-e) : W'(e);
   assign acc_in = (acc_ff << W) + AW'(pp_ff);
   assign mag    = acc_in[XW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            xm_ff   <= AW'(x_abs);
            em_ff   <= e_abs;
            neg_ff  <= x[XW-1] ^ e[W-1];
            acc_ff  <= '0;
         end else if (busy_ff) begin
            pp_ff  <= xm_ff[AW-1 -: W] * em_ff;
            xm_ff  <= xm_ff << W;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff != '0) begin
               acc_ff <= acc_in;
            end
            if (cnt_ff == CNT_W'(NL)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               prod_ff <= neg_ff ? -signed'(mag) : signed'(mag);
            end
         end
      end
   end

   assign done = done_ff;
   assign prod = prod_ff;

endmodule

### hw/rtl/mi4_div.sv
// Radix-2 restoring divider: trunc(num * 2^(2F) / den), saturated to W bits.
// One quotient bit per cycle. No package dependencies.
module mi4_div #(
   parameter int W  = 32,
   parameter int F  = 16,
   parameter int CW = 99,
   parameter int XW = 131
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [CW-1:0] num,
   input  logic signed [XW-1:0] den,
   output logic                 done,
   output logic signed [W-1:0]  quot
);

   localparam int NW    = CW + 2 * F;
   localparam int CNT_W = $clog2(NW + 1);
   localparam int RW    = XW + 1;

   logic                busy_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [NW-1:0]       sh_ff;
   logic [XW-1:0]       dm_ff;
   logic [RW-1:0]       rem_ff;
   logic [W-1:0]        q_ff;
   logic                ovf_ff;
   logic                neg_ff;
   logic                done_ff;
   logic signed [W-1:0] quot_ff;

   logic [CW-1:0] num_abs;
   logic [XW-1:0] den_abs;
   logic [RW-1:0] rem_sh;
   logic          ge;
   logic [RW-1:0] rem_in;
   logic [W-1:0]  q_in;
   logic          ovf_in;
   logic [W-1:0]  lim;
   logic [W-1:0]  mag;

   assign num_abs = num[CW-1] ? CW'(-num) : CW'(num);
   assign den_abs = den[XW-1] ? XW'(-den) : XW'(den);
   assign rem_sh  = {rem_ff[RW-2:0], sh_ff[NW-1]};
   assign ge      = rem_sh >= RW'(dm_ff);
   assign rem_in  = ge ? rem_sh - RW'(dm_ff) : rem_sh;
   assign q_in    = {q_ff[W-2:0], ge};
   assign ovf_in  = ovf_ff | q_ff[W-1];
   assign lim     = neg_ff ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
   assign mag     = (ovf_in || q_in > lim) ? lim : q_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            sh_ff   <= NW'(num_abs) << (2 * F);
            dm_ff   <= den_abs;
            rem_ff  <= '0;
            q_ff    <= '0;
            ovf_ff  <= 1'b0;
            neg_ff  <= num[CW-1] ^ den[XW-1];
         end else if (busy_ff) begin
            sh_ff  <= sh_ff << 1;
            rem_ff <= rem_in;
            q_ff   <= q_in;
            ovf_ff <= ovf_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               quot_ff <= neg_ff ? -signed'(mag) : signed'(mag);
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

### hw/rtl/matrix_inverse_4x4.sv
// 4x4 matrix inverse by the adjugate, signed fixed point.
// Uses mi4_pkg, mi4_mul (serial multiplier) and mi4_div (serial divider).
//
//   channel | dir | tdata            | tuser                     | tlast
//   req     | in  | element_value    | -                         | -
//   rsp     | out | result_value     | result_index, singular    | last_of_matrix
//
// Loading takes one element per cycle. After the sixteenth, cofactors go through
// the one limb-serial multiplier and quotients through the one bit-serial divider.
// Matrix and cofactor stores are single-port-read memories with registered read data.
// Reset returns to loading and clears the load count and the output valid flag.
// A stalled rsp side holds the sequencer; the next matrix loads while the last result waits.
module matrix_inverse_4x4 #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [mi4_pkg::PORT_W-1:0]    req_tdata,   // [31:0] element_value
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mi4_pkg::PORT_W-1:0]    rsp_tdata,   // [31:0] result_value
   output logic [mi4_pkg::USER_W-1:0]    rsp_tuser,   // [3:0] result_index, [4] singular
   output logic                          rsp_tlast    // last_of_matrix
);

   localparam int W  = DATA_WIDTH;
   localparam int CW = 3 * W + 3;
   localparam int XW = 4 * W + 3;

   typedef enum logic [3:0] {
      ST_LOAD, ST_RD_A, ST_RD_B, ST_MUL_B, ST_WAIT_B, ST_MUL_C, ST_WAIT_C,
      ST_DET_RD, ST_DET_MUL, ST_DET_WAIT, ST_OUT_RD, ST_OUT_GO, ST_OUT_DIV, ST_OUT_PUT
   } state_type;

   state_type                        state_ff;
   logic [mi4_pkg::IDX_W-1:0]        cnt_ff;
   logic [mi4_pkg::TERM_W-1:0]       term_ff;
   logic signed [XW-1:0]             acc_ff;
   logic signed [XW-1:0]             x_ff;
   logic                             sing_ff;
   logic signed [W-1:0]              val_ff;
   logic                             rsp_valid_ff;
   logic signed [W-1:0]              rsp_value_ff;
   logic [mi4_pkg::IDX_W-1:0]        rsp_index_ff;
   logic                             rsp_sing_ff;
   logic                             rsp_last_ff;

   logic signed [W-1:0]  mat_mem [16];
   logic signed [W-1:0]  mat_rdata_ff;
   logic [mi4_pkg::IDX_W-1:0] mat_raddr;
   logic                 mat_we;

   logic signed [CW-1:0] cof_mem [16];
   logic signed [CW-1:0] cof_rdata_ff;
   logic [mi4_pkg::IDX_W-1:0] cof_raddr;
   logic                 cof_we;

   logic                 mul_start;
   logic signed [XW-1:0] mul_x;
   logic                 mul_done;
   logic signed [XW-1:0] mul_prod;
   logic                 div_start;
   logic                 div_done;
   logic signed [W-1:0]  div_quot;

   logic signed [XW-1:0] term_sum;
   logic signed [XW-1:0] cof_val;
   logic signed [XW-1:0] det_sum;
   logic                 out_free;
   logic [1:0]           ci;
   logic [1:0]           cj;

   assign ci = cnt_ff[1:0];
   assign cj = cnt_ff[3:2];

   always_comb begin
      unique case (state_ff)
         ST_RD_A:                       mat_raddr = mi4_pkg::term_addr(term_ff, 2'd0, ci, cj);
         ST_RD_B:                       mat_raddr = mi4_pkg::term_addr(term_ff, 2'd1, ci, cj);
         ST_MUL_B, ST_WAIT_B, ST_MUL_C: mat_raddr = mi4_pkg::term_addr(term_ff, 2'd2, ci, cj);
         ST_DET_RD:                     mat_raddr = {ci, 2'b00};
         default:                       mat_raddr = cnt_ff;
      endcase
      cof_raddr = (state_ff == ST_DET_RD) ? {ci, 2'b00} : {ci, cj};
   end

   assign mat_we = (state_ff == ST_LOAD) && req_tvalid;

   always_ff @(posedge clock) begin
      if (mat_we) begin
         mat_mem[cnt_ff] <= signed'(req_tdata[W-1:0]);
      end
      mat_rdata_ff <= mat_mem[mat_raddr];
   end

   always_ff @(posedge clock) begin
      if (cof_we) begin
         cof_mem[cnt_ff] <= CW'(cof_val);
      end
      cof_rdata_ff <= cof_mem[cof_raddr];
   end

   assign term_sum = (term_ff < mi4_pkg::FIRST_SUB_TERM) ? acc_ff + mul_prod : acc_ff - mul_prod;
   assign cof_val  = (ci[0] ^ cj[0]) ? -term_sum : term_sum;
   assign det_sum  = acc_ff + mul_prod;
   assign cof_we   = (state_ff == ST_WAIT_C) && mul_done
                     && (term_ff == mi4_pkg::TERM_W'(mi4_pkg::TERMS - 1));

   assign mul_start = (state_ff == ST_MUL_B) || (state_ff == ST_MUL_C) || (state_ff == ST_DET_MUL);
   assign mul_x     = (state_ff == ST_DET_MUL) ? XW'(cof_rdata_ff) : x_ff;
   assign div_start = (state_ff == ST_OUT_GO) && !sing_ff;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   mi4_mul #(.W(W), .XW(XW)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .x     (mul_x),
      .e     (mat_rdata_ff),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   mi4_div #(.W(W), .F(FRAC_BITS), .CW(CW), .XW(XW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (cof_rdata_ff),
      .den   (acc_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         term_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_OUT_PUT && out_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_value_ff <= val_ff;
            rsp_index_ff <= cnt_ff;
            rsp_sing_ff  <= sing_ff;
            rsp_last_ff  <= (cnt_ff == mi4_pkg::IDX_W'(mi4_pkg::LAST_IDX));
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_LOAD: begin
               if (req_tvalid) begin
                  cnt_ff <= cnt_ff + 1'b1;
                  if (cnt_ff == mi4_pkg::IDX_W'(mi4_pkg::LAST_IDX)) begin
                     state_ff <= ST_RD_A;
                     term_ff  <= '0;
                     acc_ff   <= '0;
                  end
               end
            end
            ST_RD_A:  state_ff <= ST_RD_B;
            ST_RD_B: begin
               x_ff     <= XW'(mat_rdata_ff);
               state_ff <= ST_MUL_B;
            end
            ST_MUL_B: state_ff <= ST_WAIT_B;
            ST_WAIT_B: begin
               if (mul_done) begin
                  x_ff     <= mul_prod;
                  state_ff <= ST_MUL_C;
               end
            end
            ST_MUL_C: state_ff <= ST_WAIT_C;
            ST_WAIT_C: begin
               if (mul_done) begin
                  if (term_ff == mi4_pkg::TERM_W'(mi4_pkg::TERMS - 1)) begin
                     term_ff <= '0;
                     acc_ff  <= '0;
                     cnt_ff  <= cnt_ff + 1'b1;
                     state_ff <= (cnt_ff == mi4_pkg::IDX_W'(mi4_pkg::LAST_IDX)) ? ST_DET_RD
                                                                                  : ST_RD_A;
                  end else begin
                     acc_ff   <= term_sum;
                     term_ff  <= term_ff + 1'b1;
                     state_ff <= ST_RD_A;
                  end
               end
            end
            ST_DET_RD:  state_ff <= ST_DET_MUL;
            ST_DET_MUL: state_ff <= ST_DET_WAIT;
            ST_DET_WAIT: begin
               if (mul_done) begin
                  acc_ff <= det_sum;
                  if (cnt_ff == mi4_pkg::IDX_W'(mi4_pkg::DET_LAST)) begin
                     sing_ff  <= (det_sum == '0);
                     cnt_ff   <= '0;
                     state_ff <= ST_OUT_RD;
                  end else begin
                     cnt_ff   <= cnt_ff + 1'b1;
                     state_ff <= ST_DET_RD;
                  end
               end
            end
            ST_OUT_RD: state_ff <= ST_OUT_GO;
            ST_OUT_GO: begin
               if (sing_ff) begin
                  val_ff   <= mat_rdata_ff;
                  state_ff <= ST_OUT_PUT;
               end else begin
                  state_ff <= ST_OUT_DIV;
               end
            end
            ST_OUT_DIV: begin
               if (div_done) begin
                  val_ff   <= div_quot;
                  state_ff <= ST_OUT_PUT;
               end
            end
            ST_OUT_PUT: begin
               if (out_free) begin
                  cnt_ff   <= cnt_ff + 1'b1;
                  state_ff <= (cnt_ff == mi4_pkg::IDX_W'(mi4_pkg::LAST_IDX)) ? ST_LOAD
                                                                               : ST_OUT_RD;
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = mi4_pkg::PORT_W'(rsp_value_ff);
   assign rsp_tuser  = {rsp_sing_ff, rsp_index_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

### hw/rtl/mi4_chk.sv
// Port-level checker for matrix_inverse_4x4, bound to the top level.
// Uses assert_macros.svh and mi4_pkg.
`include "assert_macros.svh"

module mi4_chk (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic [mi4_pkg::PORT_W-1:0]    req_tdata,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [mi4_pkg::PORT_W-1:0]    rsp_tdata,
   input logic [mi4_pkg::USER_W-1:0]    rsp_tuser,
   input logic                          rsp_tlast
);

   `MI4_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp transfer dropped or changed while stalled")
   `MI4_ASSERT(a_last_idx, clock, reset, rsp_tvalid |-> (rsp_tlast == (rsp_tuser[3:0] == 4'd15)), "tlast does not match final index")
   `MI4_ASSERT(a_no_load_mid, clock, reset, rsp_tvalid && !rsp_tlast |-> !req_tready, "load accepted while a matrix is still draining")
   `MI4_ASSERT_ALWAYS(a_rst_state, clock, reset |=> !rsp_tvalid && req_tready, "reset did not return to loading")
   `MI4_ASSERT(a_no_x_in, clock, reset, req_tvalid && req_tready |-> !$isunknown(req_tdata), "unknown element transferred")

endmodule

bind matrix_inverse_4x4 mi4_chk u_mi4_chk (.*);
